[hdl/pcode_stack_machine_core_macros.svh]
// Assertion macros shared by the stack machine RTL.
`ifndef PCODE_STACK_MACHINE_CORE_MACROS_SVH
`define PCODE_STACK_MACHINE_CORE_MACROS_SVH
`ifndef SYNTH
`define PCSM_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pcsm: property violated");
`define PCSM_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("pcsm: forbidden condition seen");
`else
`define PCSM_ASSERT(name, clk, rstn, prop)
`define PCSM_NEVER(name, clk, rstn, expr)
`endif
`endif

[hdl/pcsm_pkg.sv]
`timescale 1ns / 1ps

package pcsm_pkg;

  // Sizes of the machine.
  localparam int unsigned STACK_DEPTH_DEFAULT = 512;
  localparam int unsigned CODE_DEPTH = 1024;
  localparam int unsigned PC_W = $clog2(CODE_DEPTH);
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned MAX_LEVEL = 15;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned ARG_W = 31;
  localparam int unsigned IN_W = 72;
  localparam int unsigned OUT_W = 48;

  // Instruction opcodes.
  typedef enum logic [FUNC_W-1:0] {
    FN_LIT = 3'd0,
    FN_OPR = 3'd1,
    FN_LOD = 3'd2,
    FN_STO = 3'd3,
    FN_CAL = 3'd4,
    FN_INT = 3'd5,
    FN_JMP = 3'd6,
    FN_JPC = 3'd7
  } func_e;

  // Sub-operations of opr, carried in the argument.
  localparam logic [ARG_W-1:0] OPR_RET = ARG_W'(0);
  localparam logic [ARG_W-1:0] OPR_NEG = ARG_W'(1);
  localparam logic [ARG_W-1:0] OPR_ADD = ARG_W'(2);
  localparam logic [ARG_W-1:0] OPR_SUB = ARG_W'(3);
  localparam logic [ARG_W-1:0] OPR_MUL = ARG_W'(4);
  localparam logic [ARG_W-1:0] OPR_DIV = ARG_W'(5);
  localparam logic [ARG_W-1:0] OPR_ODD = ARG_W'(6);
  localparam logic [ARG_W-1:0] OPR_EQ  = ARG_W'(8);
  localparam logic [ARG_W-1:0] OPR_NE  = ARG_W'(9);
  localparam logic [ARG_W-1:0] OPR_LT  = ARG_W'(10);
  localparam logic [ARG_W-1:0] OPR_GE  = ARG_W'(11);
  localparam logic [ARG_W-1:0] OPR_GT  = ARG_W'(12);
  localparam logic [ARG_W-1:0] OPR_LE  = ARG_W'(13);
  localparam logic [ARG_W-1:0] OPR_PRT = ARG_W'(14);
  localparam logic [ARG_W-1:0] OPR_NL  = ARG_W'(15);
  localparam logic [ARG_W-1:0] OPR_RD  = ARG_W'(16);

  // Error codes reported with each result.
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_DIV0  = 2'd2
  } err_e;

  // Operations of the shared arithmetic unit.
  typedef enum logic [3:0] {
    ALU_ADD = 4'd0,
    ALU_SUB = 4'd1,
    ALU_MUL = 4'd2,
    ALU_DIV = 4'd3,
    ALU_EQ  = 4'd4,
    ALU_NE  = 4'd5,
    ALU_LT  = 4'd6,
    ALU_GE  = 4'd7,
    ALU_GT  = 4'd8,
    ALU_LE  = 4'd9
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

endpackage

[hdl/pcsm_ram.sv]
`timescale 1ns / 1ps

module pcsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/pcsm_alu.sv]
`timescale 1ns / 1ps

module pcsm_alu (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcsm_pkg::alu_req_t               req_i,
  input  logic [pcsm_pkg::WORD_BITS-1:0]   a_i,
  input  logic [pcsm_pkg::WORD_BITS-1:0]   b_i,
  output pcsm_pkg::alu_rsp_t               rsp_o,
  output logic [pcsm_pkg::WORD_BITS-1:0]   result_o
);

  localparam int unsigned W = pcsm_pkg::WORD_BITS;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic          busy_q, busy_d;
  logic          fin_q, fin_d;
  logic          done_q, done_d;
  logic          div0_q, div0_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W-1:0]  res_q, res_d;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  // Non-division operations load the result register directly; division produces one quotient bit per cycle.
  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    div0_d = div0_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    res_d  = res_q;
    rem_sh = {rem_q, quo_q[W-1]};
    diff   = rem_sh - {1'b0, dvs_q};

    if (req_i.start) begin
      div0_d = 1'b0;
      done_d = 1'b1;
      unique case (req_i.op)
        pcsm_pkg::ALU_ADD: res_d = a_i + b_i;
        pcsm_pkg::ALU_SUB: res_d = a_i - b_i;
        pcsm_pkg::ALU_MUL: res_d = a_i * b_i;
        pcsm_pkg::ALU_EQ:  res_d = W'(a_i == b_i);
        pcsm_pkg::ALU_NE:  res_d = W'(a_i != b_i);
        pcsm_pkg::ALU_LT:  res_d = W'($signed(a_i) < $signed(b_i));
        pcsm_pkg::ALU_GE:  res_d = W'($signed(a_i) >= $signed(b_i));
        pcsm_pkg::ALU_GT:  res_d = W'($signed(a_i) > $signed(b_i));
        pcsm_pkg::ALU_LE:  res_d = W'($signed(a_i) <= $signed(b_i));
        pcsm_pkg::ALU_DIV: begin
          if (b_i == '0) begin
            div0_d = 1'b1;
          end else begin
            // Divide magnitudes and fix the sign at the end.
            done_d = 1'b0;
            busy_d = 1'b1;
            cnt_d  = '0;
            rem_d  = '0;
            quo_d  = a_i[W-1] ? -a_i : a_i;
            dvs_d  = b_i[W-1] ? -b_i : b_i;
            neg_d  = a_i[W-1] ^ b_i[W-1];
          end
        end
        default: res_d = '0;
      endcase
    end else if (busy_q) begin
      // Restoring step: shift in one dividend bit, subtract if it fits.
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      res_d  = neg_q ? -quo_q : quo_q;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      div0_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      div0_q <= div0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    res_q <= res_d;
  end

  assign rsp_o    = '{done: done_q, div0: div0_q};
  assign result_o = res_q;

endmodule

[hdl/pcode_stack_machine_core.sv]
`timescale 1ns / 1ps
// Steps: lod, sto and cal first walk the static links; then every request executes, and jpc,
// negate, odd, print, lod, sto, return and the arithmetic opr read the stack and write back.
// Division produces one quotient bit a cycle in the shared unit.
// Throughput: one request at a time; the next is taken once the result register loads, and
// a finished instruction waits until the output register is free.
// Reset: asynchronous, active low; then the stack RAM is cleared before the first request.

`include "pcode_stack_machine_core_macros.svh"

module pcode_stack_machine_core #(
  parameter int unsigned STACK_DEPTH = pcsm_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // func[2:0], level[6:3], arg[37:7], read_value[69:38], zero pad[71:70]
  input  logic [pcsm_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // next_pc[9:0], halted[10], print_valid[11], print_value[43:12], newline[44],
  // read_taken[45], error[47:46]
  output logic [pcsm_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned W = pcsm_pkg::WORD_BITS;
  localparam int unsigned PW = pcsm_pkg::PC_W;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned TW = $clog2(STACK_DEPTH + 1);
  localparam logic [31:0] SD32 = 32'(STACK_DEPTH);
  localparam logic [TW-1:0] SD_T = TW'(STACK_DEPTH);
  localparam logic [W-1:0] SD_W = W'(STACK_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(STACK_DEPTH - 1);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_WALK  = 12'b000000000100,
    S_LINK  = 12'b000000001000,
    S_EXEC  = 12'b000000010000,
    S_RDA   = 12'b000000100000,
    S_RDB   = 12'b000001000000,
    S_ALU   = 12'b000010000000,
    S_WB    = 12'b000100000000,
    S_CAL1  = 12'b001000000000,
    S_CAL2  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_e;

  // What the write-back step does with the data read.
  typedef enum logic [2:0] {
    ACT_LOD, ACT_STO, ACT_JPC, ACT_RET, ACT_NEG, ACT_ODD, ACT_BIN, ACT_PRT
  } act_e;

  state_e                              state_q, state_d;
  act_e                                act_q, act_d;
  pcsm_pkg::alu_op_e                   aluop_q, aluop_d;
  pcsm_pkg::func_e                     func_q, func_d;
  pcsm_pkg::err_e                      err_q, err_d;
  logic [pcsm_pkg::LEVEL_W-1:0]        lev_q, lev_d;
  logic [pcsm_pkg::ARG_W-1:0]          arg_q, arg_d;
  logic [W-1:0]                        rv_q, rv_d;
  logic [W-1:0]                        a_q, a_d;
  logic [W-1:0]                        pval_q, pval_d;
  logic [PW-1:0]                       pc_q, pc_d;
  logic [AW-1:0]                       fb_q, fb_d;
  logic [AW-1:0]                       b_q, b_d;
  logic [AW-1:0]                       clr_q, clr_d;
  logic [TW-1:0]                       t_q, t_d;
  logic                                pv_q, pv_d;
  logic                                nl_q, nl_d;
  logic                                rt_q, rt_d;
  logic                                ov_q, ov_d;
  logic [pcsm_pkg::OUT_W-1:0]          odata_q, odata_d;

  logic                                mem_we;
  logic [AW-1:0]                       mem_waddr;
  logic [W-1:0]                        mem_wdata;
  logic [AW-1:0]                       mem_raddr;
  logic [W-1:0]                        mem_rdata;
  pcsm_pkg::alu_req_t                  alu_req;
  pcsm_pkg::alu_rsp_t                  alu_rsp;
  logic [W-1:0]                        alu_res;

  pcsm_pkg::func_e                     in_func;
  logic [pcsm_pkg::LEVEL_W-1:0]        in_level;
  logic [31:0]                         badr32;
  logic [31:0]                         targ32;
  logic [TW-1:0]                       t_m1;
  logic [TW-1:0]                       t_m2;
  logic                                link_ok;

  assign in_func  = pcsm_pkg::func_e'(s_axis_tdata[2:0]);
  assign in_level = s_axis_tdata[6:3];
  assign badr32   = 32'(b_q) + 32'(arg_q);
  assign targ32   = 32'(t_q) + 32'(arg_q);
  assign t_m1     = t_q - TW'(1);
  assign t_m2     = t_q - TW'(2);
  assign link_ok  = !mem_rdata[W-1] && (mem_rdata < SD_W);

  // Sequencer: walks links, reads operands, drives the shared unit, writes back.
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    aluop_d   = aluop_q;
    func_d    = func_q;
    err_d     = err_q;
    lev_d     = lev_q;
    arg_d     = arg_q;
    rv_d      = rv_q;
    a_d       = a_q;
    pval_d    = pval_q;
    pc_d      = pc_q;
    fb_d      = fb_q;
    b_d       = b_q;
    clr_d     = clr_q;
    t_d       = t_q;
    pv_d      = pv_q;
    nl_d      = nl_q;
    rt_d      = rt_q;
    ov_d      = ov_q;
    odata_d   = odata_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    alu_req   = '{start: 1'b0, op: pcsm_pkg::ALU_ADD};
    s_axis_tready = (state_q == S_IDLE);

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d = in_func;
          lev_d  = in_level;
          arg_d  = s_axis_tdata[37:7];
          rv_d   = s_axis_tdata[69:38];
          pc_d   = pc_q + PW'(1);
          b_d    = fb_q;
          err_d  = pcsm_pkg::ERR_NONE;
          pv_d   = 1'b0;
          pval_d = '0;
          nl_d   = 1'b0;
          rt_d   = 1'b0;
          if (in_func == pcsm_pkg::FN_LOD || in_func == pcsm_pkg::FN_STO ||
              in_func == pcsm_pkg::FN_CAL) begin
            if (32'(in_level) > 32'(pcsm_pkg::MAX_LEVEL)) begin
              err_d   = pcsm_pkg::ERR_RANGE;
              state_d = S_DONE;
            end else begin
              state_d = S_WALK;
            end
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      // Follow one static link per pass through the walk and link states.
      S_WALK: begin
        if (lev_q == '0) begin
          state_d = S_EXEC;
        end else begin
          mem_raddr = b_q;
          state_d   = S_LINK;
        end
      end

      S_LINK: begin
        if (!link_ok) begin
          err_d   = pcsm_pkg::ERR_RANGE;
          state_d = S_DONE;
        end else begin
          b_d     = mem_rdata[AW-1:0];
          lev_d   = lev_q - pcsm_pkg::LEVEL_W'(1);
          state_d = S_WALK;
        end
      end

      // Range checks, then the first memory access of the instruction, if it has one.
      S_EXEC: begin
        state_d = S_DONE;
        unique case (func_q)
          pcsm_pkg::FN_LIT: begin
            if (t_q >= SD_T) begin
              err_d = pcsm_pkg::ERR_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = t_q[AW-1:0];
              mem_wdata = W'(arg_q);
              t_d       = t_q + TW'(1);
            end
          end
          pcsm_pkg::FN_LOD: begin
            if (badr32 >= SD32 || t_q >= SD_T) begin
              err_d = pcsm_pkg::ERR_RANGE;
            end else begin
              mem_raddr = badr32[AW-1:0];
              act_d     = ACT_LOD;
              state_d   = S_WB;
            end
          end
          pcsm_pkg::FN_STO: begin
            if (t_q == '0 || badr32 >= SD32) begin
              err_d = pcsm_pkg::ERR_RANGE;
            end else begin
              mem_raddr = t_m1[AW-1:0];
              act_d     = ACT_STO;
              state_d   = S_WB;
            end
          end
          pcsm_pkg::FN_CAL: begin
            if (32'(t_q) + 32'd2 >= SD32) begin
              err_d = pcsm_pkg::ERR_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = t_q[AW-1:0];
              mem_wdata = W'(b_q);
              state_d   = S_CAL1;
            end
          end
          pcsm_pkg::FN_INT: begin
            if (targ32 > SD32) begin
              err_d = pcsm_pkg::ERR_RANGE;
            end else begin
              t_d = targ32[TW-1:0];
            end
          end
          pcsm_pkg::FN_JMP: begin
            pc_d = arg_q[PW-1:0];
          end
          pcsm_pkg::FN_JPC: begin
            if (t_q == '0) begin
              err_d = pcsm_pkg::ERR_RANGE;
            end else begin
              mem_raddr = t_m1[AW-1:0];
              act_d     = ACT_JPC;
              state_d   = S_WB;
            end
          end
          pcsm_pkg::FN_OPR: begin
            case (arg_q)
              pcsm_pkg::OPR_RET: begin
                if (32'(fb_q) + 32'd2 >= SD32) begin
                  err_d = pcsm_pkg::ERR_RANGE;
                end else begin
                  mem_raddr = fb_q + AW'(1);
                  act_d     = ACT_RET;
                  state_d   = S_RDA;
                end
              end
              pcsm_pkg::OPR_NEG, pcsm_pkg::OPR_ODD, pcsm_pkg::OPR_PRT: begin
                if (t_q == '0) begin
                  err_d = pcsm_pkg::ERR_RANGE;
                end else begin
                  mem_raddr = t_m1[AW-1:0];
                  act_d     = (arg_q == pcsm_pkg::OPR_NEG) ? ACT_NEG :
                              (arg_q == pcsm_pkg::OPR_ODD) ? ACT_ODD : ACT_PRT;
                  state_d   = S_WB;
                end
              end
              pcsm_pkg::OPR_ADD, pcsm_pkg::OPR_SUB, pcsm_pkg::OPR_MUL,
              pcsm_pkg::OPR_DIV, pcsm_pkg::OPR_EQ, pcsm_pkg::OPR_NE,
              pcsm_pkg::OPR_LT, pcsm_pkg::OPR_GE, pcsm_pkg::OPR_GT,
              pcsm_pkg::OPR_LE: begin
                if (t_q < TW'(2)) begin
                  err_d = pcsm_pkg::ERR_RANGE;
                end else begin
                  mem_raddr = t_m2[AW-1:0];
                  act_d     = ACT_BIN;
                  state_d   = S_RDA;
                  case (arg_q)
                    pcsm_pkg::OPR_ADD: aluop_d = pcsm_pkg::ALU_ADD;
                    pcsm_pkg::OPR_SUB: aluop_d = pcsm_pkg::ALU_SUB;
                    pcsm_pkg::OPR_MUL: aluop_d = pcsm_pkg::ALU_MUL;
                    pcsm_pkg::OPR_DIV: aluop_d = pcsm_pkg::ALU_DIV;
                    pcsm_pkg::OPR_EQ:  aluop_d = pcsm_pkg::ALU_EQ;
                    pcsm_pkg::OPR_NE:  aluop_d = pcsm_pkg::ALU_NE;
                    pcsm_pkg::OPR_LT:  aluop_d = pcsm_pkg::ALU_LT;
                    pcsm_pkg::OPR_GE:  aluop_d = pcsm_pkg::ALU_GE;
                    pcsm_pkg::OPR_GT:  aluop_d = pcsm_pkg::ALU_GT;
                    default:           aluop_d = pcsm_pkg::ALU_LE;
                  endcase
                end
              end
              pcsm_pkg::OPR_NL: begin
                nl_d = 1'b1;
              end
              pcsm_pkg::OPR_RD: begin
                if (t_q >= SD_T) begin
                  err_d = pcsm_pkg::ERR_RANGE;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = t_q[AW-1:0];
                  mem_wdata = rv_q;
                  t_d       = t_q + TW'(1);
                  rt_d      = 1'b1;
                end
              end
              default: begin
                // Unknown sub-operations leave the state alone.
              end
            endcase
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // First operand or saved base is here; fetch the next word.
      S_RDA: begin
        if (act_q == ACT_RET) begin
          if (!link_ok) begin
            err_d   = pcsm_pkg::ERR_RANGE;
            state_d = S_DONE;
          end else begin
            a_d       = mem_rdata;
            mem_raddr = fb_q + AW'(2);
            state_d   = S_WB;
          end
        end else begin
          a_d       = mem_rdata;
          mem_raddr = t_m1[AW-1:0];
          state_d   = S_RDB;
        end
      end

      S_RDB: begin
        alu_req = '{start: 1'b1, op: aluop_q};
        state_d = S_ALU;
      end

      S_ALU: begin
        if (alu_rsp.done) begin
          state_d = S_WB;
        end
      end

      S_WB: begin
        state_d = S_DONE;
        unique case (act_q)
          ACT_LOD: begin
            mem_we    = 1'b1;
            mem_waddr = t_q[AW-1:0];
            mem_wdata = mem_rdata;
            t_d       = t_q + TW'(1);
          end
          ACT_STO: begin
            mem_we    = 1'b1;
            mem_waddr = badr32[AW-1:0];
            mem_wdata = mem_rdata;
            t_d       = t_m1;
          end
          ACT_JPC: begin
            t_d = t_m1;
            if (mem_rdata == '0) begin
              pc_d = arg_q[PW-1:0];
            end
          end
          ACT_RET: begin
            t_d  = TW'(fb_q);
            fb_d = a_q[AW-1:0];
            pc_d = mem_rdata[PW-1:0];
          end
          ACT_NEG: begin
            mem_we    = 1'b1;
            mem_waddr = t_m1[AW-1:0];
            mem_wdata = -mem_rdata;
          end
          ACT_ODD: begin
            mem_we    = 1'b1;
            mem_waddr = t_m1[AW-1:0];
            mem_wdata = {{(W-1){1'b0}}, mem_rdata[0]};
          end
          ACT_BIN: begin
            if (alu_rsp.div0) begin
              err_d = pcsm_pkg::ERR_DIV0;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = t_m2[AW-1:0];
              mem_wdata = alu_res;
              t_d       = t_m1;
            end
          end
          ACT_PRT: begin
            pval_d = mem_rdata;
            pv_d   = 1'b1;
            t_d    = t_m1;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // Call frame: saved base and return counter.
      S_CAL1: begin
        mem_we    = 1'b1;
        mem_waddr = t_q[AW-1:0] + AW'(1);
        mem_wdata = W'(fb_q);
        state_d   = S_CAL2;
      end

      S_CAL2: begin
        mem_we    = 1'b1;
        mem_waddr = t_q[AW-1:0] + AW'(2);
        mem_wdata = W'(pc_q);
        fb_d      = t_q[AW-1:0];
        pc_d      = arg_q[PW-1:0];
        state_d   = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          odata_d = {err_q, rt_q, nl_q, pval_q, pv_q, (pc_q == '0), pc_q};
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pc_q    <= '0;
      fb_q    <= '0;
      t_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pc_q    <= pc_d;
      fb_q    <= fb_d;
      t_q     <= t_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    aluop_q <= aluop_d;
    func_q  <= func_d;
    err_q   <= err_d;
    lev_q   <= lev_d;
    arg_q   <= arg_d;
    rv_q    <= rv_d;
    a_q     <= a_d;
    pval_q  <= pval_d;
    b_q     <= b_d;
    pv_q    <= pv_d;
    nl_q    <= nl_d;
    rt_q    <= rt_d;
    odata_q <= odata_d;
  end

  pcsm_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pcsm_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (a_q),
    .b_i      (mem_rdata),
    .rsp_o    (alu_rsp),
    .result_o (alu_res)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;

  // The stack top never passes the stack depth.
  `PCSM_NEVER(a_top_range, clk_i, rst_ni, t_q > SD_T)
  // An accepted request always starts work.
  `PCSM_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
  // The shared unit only answers while the sequencer waits for it.
  `PCSM_ASSERT(a_alu_done_in_wait, clk_i, rst_ni, alu_rsp.done |-> (state_q == S_ALU))
  // The halt flag agrees with the reported counter.
  `PCSM_ASSERT(a_halt_flag, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[10] == (m_axis_tdata[9:0] == '0)))

endmodule
